// File: hw/rtl/descending_priority_queue_defines.svh
// Assertion macros shared by the checker of the priority queue.
`ifndef DESCENDING_PRIORITY_QUEUE_DEFINES_SVH
`define DESCENDING_PRIORITY_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("priority queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define DPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("priority queue check failed");

`endif

// File: hw/rtl/dpq_pkg.sv
`default_nettype none

package dpq_pkg;

  localparam int KEY_W    = 32;
  localparam int TAG_W    = 16;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 56;
  localparam int OUT_W    = 56;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/dpq_cell.sv
`default_nettype none

module dpq_cell (
  input  wire logic           clk,
  input  wire dpq_pkg::ctrl_t ctrl,
  input  wire logic           occupied,
  input  wire logic           left_stay,
  input  wire dpq_pkg::entry_t left_entry,
  input  wire dpq_pkg::entry_t right_entry,
  output logic                stay,
  output dpq_pkg::entry_t     entry,
  output dpq_pkg::entry_t     entry_next
);
  import dpq_pkg::*;

  // An occupied cell whose key is at least the new key keeps its entry on a push.
  assign stay = occupied && (entry.key >= ctrl.entry.key);

  always_comb begin
    entry_next = entry;
    if (ctrl.push) begin
      if (!stay) begin
        entry_next = left_stay ? ctrl.entry : left_entry;
      end
    end else if (ctrl.pop) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// File: hw/rtl/descending_priority_queue.sv
// Bounded priority queue of DEPTH entries, largest key at the head, equal keys
// leaving in arrival order. Each input transaction is a push or a pop and
// yields exactly one output transaction with the new head, the count and a
// status. The queue is a row of cells that all compare the pushed key in
// parallel and shift toward the tail on a push or toward the head on a pop,
// so one transaction is taken every cycle unless the output is stalled; its
// result reaches the output register in the next cycle. Input is accepted
// whenever the output register is empty or being read in the same cycle.
`default_nettype none

module descending_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // operation [0], entry_key [32:1], entry_tag [48:33], zero fill [55:49]
  input  wire logic [dpq_pkg::IN_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // head_key [31:0], head_tag [47:32], count [52:48], is_empty [53],
  // status [55:54]
  output logic [dpq_pkg::OUT_W-1:0]      m_tdata
);
  import dpq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]       occ;
  logic [CW-1:0]       occ_next;
  logic                accept;
  logic                in_op;
  entry_t              in_entry;
  logic                full;
  logic                empty;
  logic [STATUS_W-1:0] status_next;
  ctrl_t               ctrl;
  logic                cell_stay [DEPTH];
  entry_t              cell_entry [DEPTH];
  entry_t              cell_entry_next [DEPTH];
  entry_t              head_next;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign in_op    = s_tdata[0];
  assign in_entry.key = s_tdata[KEY_W:1];
  assign in_entry.tag = s_tdata[KEY_W+TAG_W:KEY_W+1];
  assign full     = (occ == CW'(DEPTH));
  assign empty    = (occ == '0);

  always_comb begin
    ctrl.push   = accept && (in_op == OP_PUSH) && !full;
    ctrl.pop    = accept && (in_op == OP_POP) && !empty;
    ctrl.entry  = in_entry;
    occ_next    = occ;
    status_next = ST_DONE;
    if (ctrl.push) begin
      occ_next = occ + CW'(1);
    end else if (ctrl.pop) begin
      occ_next = occ - CW'(1);
    end
    if (in_op == OP_PUSH && full) begin
      status_next = ST_PUSH_FULL;
    end else if (in_op == OP_POP && empty) begin
      status_next = ST_POP_EMPTY;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dpq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occ > CW'(i)),
      .left_stay  ((i == 0) ? 1'b1 : cell_stay[(i == 0) ? 0 : i - 1]),
      .left_entry (cell_entry[(i == 0) ? 0 : i - 1]),
      .right_entry(cell_entry[(i == DEPTH - 1) ? i : i + 1]),
      .stay       (cell_stay[i]),
      .entry      (cell_entry[i]),
      .entry_next (cell_entry_next[i])
    );
  end

  assign head_next = (occ_next == '0) ? '0 : cell_entry_next[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      occ      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      occ <= occ_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {status_next, occ_next == '0, COUNT_W'(occ_next),
                  head_next.tag, head_next.key};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dpq_checker.sv
`default_nettype none

`include "descending_priority_queue_defines.svh"

module dpq_checker (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     s_tvalid,
  input wire logic                     s_tready,
  input wire logic [dpq_pkg::IN_W-1:0]  s_tdata,
  input wire logic                     m_tvalid,
  input wire logic                     m_tready,
  input wire logic [dpq_pkg::OUT_W-1:0] m_tdata
);
  import dpq_pkg::*;

  `DPQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `DPQ_ASSERT_SAME(a_empty_flag, m_tvalid, m_tdata[53] == (m_tdata[52:48] == 5'd0))
  `DPQ_ASSERT_SAME(a_empty_head, m_tvalid && m_tdata[53], m_tdata[47:0] == 48'd0)
  `DPQ_ASSERT_SAME(a_status_code, m_tvalid, m_tdata[55:54] != 2'd3)
  `DPQ_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid)

endmodule

bind descending_priority_queue dpq_checker u_dpq_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

`default_nettype wire
